// ===== hdl/rpb_pkg.sv =====
// Shared types, codes and defaults for the refcounted packet buffer pool.
`default_nettype none

package rpb_pkg;

  localparam int unsigned MAX_HANDLES_DEF = 32;
  localparam int unsigned MAX_BUFFERS_DEF = 32;

  localparam logic [5:0]  HANDLE_COUNT_RST = 6'd26;
  localparam logic [5:0]  BUFFER_COUNT_RST = 6'd24;
  localparam logic [15:0] BUFFER_BYTES_RST = 16'd1666;

  localparam int unsigned IN_W   = 24;
  localparam int unsigned OUT_W  = 80;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_HANDLE_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BUFFER_COUNT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_BUFFER_BYTES = 2'd2;

  typedef enum logic [2:0] {
    ACT_INIT    = 3'd0,
    ACT_ALLOC   = 3'd1,
    ACT_FREE    = 3'd2,
    ACT_CLONE   = 3'd3,
    ACT_READCLR = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HANDLE = 2'd1,
    ST_NO_BUFFER = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  localparam logic [15:0] FAIL_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ===== hdl/refcounted_packet_buffer_pool_unit.sv =====
// Refcounted packet buffer pool: sequencer, free-list pointers and counters.
//
// Usage: commands enter on the s_axis channel as one item each (action, request length,
// handle) and each command gives exactly one result item on the m_axis channel.
// Configuration (handle count, buffer count, buffer bytes) is written through the
// cfg_we_i / cfg_index_i / cfg_data_i port; the two counts take effect at the next init,
// buffer bytes at the next alloc commit. Throughput: one item at a time. Alloc, free
// and clone run accept (free-list and binding reads), reference count read and
// write-back commit; read-and-clear and undefined actions run accept and commit.
// Init sweeps both free-list memories, one entry a cycle, in index order.
// The result sits in an output register; the next item is accepted while it waits.
// If the receiver stalls and the output register is still full, the commit step
// holds (no state changes) until the register frees up.
// Reset: both free lists empty, counters, peaks and failure count zero, no handle
// live, registers back to 26 / 24 / 1666. Free-list memories hold nothing valid
// until the first init.
`default_nettype none

module refcounted_packet_buffer_pool_unit #(
  parameter int unsigned MAX_HANDLES = rpb_pkg::MAX_HANDLES_DEF,
  parameter int unsigned MAX_BUFFERS = rpb_pkg::MAX_BUFFERS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rpb_pkg::CFG_IW-1:0]  cfg_index_i,
  input  wire logic [rpb_pkg::CFG_DW-1:0]  cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // action[2:0], request_length[18:3], handle[23:19]
  input  wire logic [rpb_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // status[1:0], new_handle[6:2], buffer_index[11:7], granted_bytes[28:12],
  // ref_count[34:29], buffer_released[35], handles_used[41:36], buffers_used[47:42],
  // handles_peak[53:48], buffers_peak[59:54], failure_count[75:60], zero[79:76]
  output logic      [rpb_pkg::OUT_W-1:0]   m_axis_tdata
);

  localparam int unsigned HW   = $clog2(MAX_HANDLES);
  localparam int unsigned BW   = $clog2(MAX_BUFFERS);
  localparam int unsigned HCW  = $clog2(MAX_HANDLES + 1);
  localparam int unsigned BCW  = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned HSW  = HCW + 1;
  localparam int unsigned BSW  = BCW + 1;
  localparam int unsigned RW   = HCW;
  localparam int unsigned MAXD = (MAX_HANDLES > MAX_BUFFERS) ? MAX_HANDLES : MAX_BUFFERS;
  localparam int unsigned IW   = $clog2(MAXD);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_INIT,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [5:0]  hcnt_cfg_q, bcnt_cfg_q;
  logic [15:0] bytes_cfg_q;

  // latched item
  logic [2:0]    action_q, action_d;
  logic [15:0]   len_q, len_d;
  logic [HW-1:0] hin_q, hin_d;
  logic          src_ok_q, src_ok_d;

  // free-list pointers, counters
  logic [HW-1:0]  hhead_q, hhead_d;
  logic [HCW-1:0] hcount_q, hcount_d;
  logic [BW-1:0]  bhead_q, bhead_d;
  logic [BCW-1:0] bcount_q, bcount_d;
  logic [HCW-1:0] hused_q, hused_d, hpeak_q, hpeak_d;
  logic [BCW-1:0] bused_q, bused_d, bpeak_q, bpeak_d;
  logic [15:0]    fail_q, fail_d;
  logic [MAX_HANDLES-1:0] live_q, live_d;
  logic [IW-1:0]  sweep_q, sweep_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [rpb_pkg::OUT_W-1:0] out_data_q, out_data_d;

  // memory ports
  logic          hf_we, hf_re, bf_we, bf_re, hb_we, hb_re, rf_we, rf_re;
  logic [HW-1:0] hf_waddr, hf_wdata, hf_rdata, hb_waddr, hb_raddr;
  logic [BW-1:0] bf_waddr, bf_wdata, bf_rdata, hb_wdata, hb_rdata, rf_waddr;
  logic [RW-1:0] rf_wdata, rf_rdata;

  logic          in_accept, out_free, commit;
  logic [4:0]    in_handle;
  logic          in_range, in_live;
  logic [HSW-1:0] htail_sum;
  logic [BSW-1:0] btail_sum;
  logic [HW-1:0]  htail, hhead_inc;
  logic [BW-1:0]  btail, bhead_inc;
  logic [HCW-1:0] hinit;
  logic [BCW-1:0] binit;
  logic [15:0]    fail_inc;
  logic [HCW-1:0] hused_inc;
  logic [BCW-1:0] bused_inc;
  logic [RW-1:0]  ref_dec;

  // result fields
  logic [1:0]  r_status;
  logic [4:0]  r_nh, r_bi;
  logic [16:0] r_granted;
  logic [5:0]  r_refc;
  logic        r_rel;
  logic [15:0] r_fc;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign commit        = (state_q == S_COMMIT) && out_free;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign in_handle = s_axis_tdata[23:19];
  assign in_range  = 32'(in_handle) < MAX_HANDLES;
  assign in_live   = in_range ? live_q[HW'(in_handle)] : 1'b0;

  // tail = (head + count) mod depth, sum stays below twice the depth
  assign htail_sum = HSW'(hhead_q) + HSW'(hcount_q);
  assign htail     = (htail_sum >= HSW'(MAX_HANDLES)) ? HW'(htail_sum - HSW'(MAX_HANDLES))
                                                       : HW'(htail_sum);
  assign btail_sum = BSW'(bhead_q) + BSW'(bcount_q);
  assign btail     = (btail_sum >= BSW'(MAX_BUFFERS)) ? BW'(btail_sum - BSW'(MAX_BUFFERS))
                                                       : BW'(btail_sum);
  assign hhead_inc = (hhead_q == HW'(MAX_HANDLES - 1)) ? '0 : hhead_q + 1'b1;
  assign bhead_inc = (bhead_q == BW'(MAX_BUFFERS - 1)) ? '0 : bhead_q + 1'b1;

  assign hinit = (9'(hcnt_cfg_q) > 9'(MAX_HANDLES)) ? HCW'(MAX_HANDLES) : HCW'(hcnt_cfg_q);
  assign binit = (9'(bcnt_cfg_q) > 9'(MAX_BUFFERS)) ? BCW'(MAX_BUFFERS) : BCW'(bcnt_cfg_q);

  assign fail_inc  = (fail_q == rpb_pkg::FAIL_MAX) ? fail_q : fail_q + 16'd1;
  assign hused_inc = hused_q + 1'b1;
  assign bused_inc = bused_q + 1'b1;
  assign ref_dec   = (rf_rdata == '0) ? '0 : rf_rdata - 1'b1;

  // read strobes: list heads and binding at accept, reference count in the following cycle
  assign hf_re    = in_accept;
  assign bf_re    = in_accept;
  assign hb_re    = in_accept;
  assign hb_raddr = HW'(in_handle);
  assign rf_re    = (state_q == S_READ);

  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    len_d       = len_q;
    hin_d       = hin_q;
    src_ok_d    = src_ok_q;
    sweep_d     = sweep_q;
    hhead_d     = hhead_q;
    hcount_d    = hcount_q;
    bhead_d     = bhead_q;
    bcount_d    = bcount_q;
    hused_d     = hused_q;
    bused_d     = bused_q;
    hpeak_d     = hpeak_q;
    bpeak_d     = bpeak_q;
    fail_d      = fail_q;
    live_d      = live_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    hf_we    = 1'b0;
    hf_waddr = htail;
    hf_wdata = hf_rdata;
    bf_we    = 1'b0;
    bf_waddr = btail;
    bf_wdata = hb_rdata;
    hb_we    = 1'b0;
    hb_waddr = hf_rdata;
    hb_wdata = bf_rdata;
    rf_we    = 1'b0;
    rf_waddr = bf_rdata;
    rf_wdata = RW'(1);

    r_status  = rpb_pkg::ST_OK;
    r_nh      = '0;
    r_bi      = '0;
    r_granted = '0;
    r_refc    = '0;
    r_rel     = 1'b0;
    r_fc      = fail_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          action_d = s_axis_tdata[2:0];
          len_d    = s_axis_tdata[18:3];
          hin_d    = HW'(in_handle);
          src_ok_d = in_live;
          sweep_d  = '0;
          case (s_axis_tdata[2:0])
            rpb_pkg::ACT_INIT:  state_d = S_INIT;
            rpb_pkg::ACT_ALLOC,
            rpb_pkg::ACT_FREE,
            rpb_pkg::ACT_CLONE: state_d = S_READ;
            default:            state_d = S_COMMIT;
          endcase
        end
      end
      S_READ: begin
        state_d = S_COMMIT;
      end
      S_INIT: begin
        // rebuild both lists in index order
        hf_we    = 32'(sweep_q) < MAX_HANDLES;
        hf_waddr = HW'(sweep_q);
        hf_wdata = HW'(sweep_q);
        bf_we    = 32'(sweep_q) < MAX_BUFFERS;
        bf_waddr = BW'(sweep_q);
        bf_wdata = BW'(sweep_q);
        sweep_d  = sweep_q + 1'b1;
        if (sweep_q == IW'(MAXD - 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
          case (action_q)
            rpb_pkg::ACT_INIT: begin
              live_d   = '0;
              hhead_d  = '0;
              hcount_d = hinit;
              bhead_d  = '0;
              bcount_d = binit;
              hused_d  = '0;
              bused_d  = '0;
              hpeak_d  = '0;
              bpeak_d  = '0;
            end
            rpb_pkg::ACT_ALLOC: begin
              if (hcount_q == '0) begin
                r_status = rpb_pkg::ST_NO_HANDLE;
                fail_d   = fail_inc;
              end else if (len_q > bytes_cfg_q || bcount_q == '0) begin
                // handle rotates from head to tail
                r_status = (len_q > bytes_cfg_q) ? rpb_pkg::ST_TOO_LARGE
                                                 : rpb_pkg::ST_NO_BUFFER;
                fail_d   = fail_inc;
                hf_we    = 1'b1;
                hhead_d  = hhead_inc;
              end else begin
                hhead_d  = hhead_inc;
                hcount_d = hcount_q - 1'b1;
                bhead_d  = bhead_inc;
                bcount_d = bcount_q - 1'b1;
                hused_d  = hused_inc;
                bused_d  = bused_inc;
                if (hused_inc > hpeak_q) hpeak_d = hused_inc;
                if (bused_inc > bpeak_q) bpeak_d = bused_inc;
                live_d[hf_rdata] = 1'b1;
                hb_we     = 1'b1;
                rf_we     = 1'b1;
                r_nh      = 5'(hf_rdata);
                r_bi      = 5'(bf_rdata);
                r_refc    = 6'd1;
                r_granted = (17'(len_q) + 17'd3) & ~17'd3;
              end
            end
            rpb_pkg::ACT_FREE: begin
              if (src_ok_q) begin
                rf_we    = 1'b1;
                rf_waddr = hb_rdata;
                rf_wdata = ref_dec;
                if (ref_dec == '0) begin
                  if (bcount_q != BCW'(MAX_BUFFERS)) begin
                    bf_we    = 1'b1;
                    bcount_d = bcount_q + 1'b1;
                  end
                  if (bused_q != '0) bused_d = bused_q - 1'b1;
                  r_rel = 1'b1;
                end
                live_d[hin_q] = 1'b0;
                if (hcount_q != HCW'(MAX_HANDLES)) begin
                  hf_we    = 1'b1;
                  hf_wdata = hin_q;
                  hcount_d = hcount_q + 1'b1;
                end
                if (hused_q != '0) hused_d = hused_q - 1'b1;
                r_bi   = 5'(hb_rdata);
                r_refc = 6'(ref_dec);
              end
            end
            rpb_pkg::ACT_CLONE: begin
              if (!src_ok_q) begin
                r_status = rpb_pkg::ST_NO_HANDLE;
              end else if (hcount_q == '0) begin
                r_status = rpb_pkg::ST_NO_HANDLE;
                fail_d   = fail_inc;
              end else begin
                hhead_d  = hhead_inc;
                hcount_d = hcount_q - 1'b1;
                hused_d  = hused_inc;
                if (hused_inc > hpeak_q) hpeak_d = hused_inc;
                live_d[hf_rdata] = 1'b1;
                hb_we    = 1'b1;
                hb_wdata = hb_rdata;
                rf_we    = 1'b1;
                rf_waddr = hb_rdata;
                rf_wdata = rf_rdata + 1'b1;
                r_nh     = 5'(hf_rdata);
                r_bi     = 5'(hb_rdata);
                r_refc   = 6'(rf_rdata + 1'b1);
              end
            end
            rpb_pkg::ACT_READCLR: begin
              fail_d = '0;
            end
            default: begin
            end
          endcase
          // failure count shown after the action, or before the clear for read-and-clear
          r_fc        = (action_q == rpb_pkg::ACT_READCLR) ? fail_q : fail_d;
          out_valid_d = 1'b1;
          out_data_d  = {4'd0, r_fc, 6'(bpeak_d), 6'(hpeak_d), 6'(bused_d), 6'(hused_d),
                         r_rel, r_refc, r_granted, r_bi, r_nh, r_status};
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hcnt_cfg_q  <= rpb_pkg::HANDLE_COUNT_RST;
      bcnt_cfg_q  <= rpb_pkg::BUFFER_COUNT_RST;
      bytes_cfg_q <= rpb_pkg::BUFFER_BYTES_RST;
      action_q    <= '0;
      src_ok_q    <= 1'b0;
      sweep_q     <= '0;
      hhead_q     <= '0;
      hcount_q    <= '0;
      bhead_q     <= '0;
      bcount_q    <= '0;
      hused_q     <= '0;
      bused_q     <= '0;
      hpeak_q     <= '0;
      bpeak_q     <= '0;
      fail_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      action_q    <= action_d;
      src_ok_q    <= src_ok_d;
      sweep_q     <= sweep_d;
      hhead_q     <= hhead_d;
      hcount_q    <= hcount_d;
      bhead_q     <= bhead_d;
      bcount_q    <= bcount_d;
      hused_q     <= hused_d;
      bused_q     <= bused_d;
      hpeak_q     <= hpeak_d;
      bpeak_q     <= bpeak_d;
      fail_q      <= fail_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          rpb_pkg::CFG_HANDLE_COUNT: hcnt_cfg_q  <= cfg_data_i[5:0];
          rpb_pkg::CFG_BUFFER_COUNT: bcnt_cfg_q  <= cfg_data_i[5:0];
          rpb_pkg::CFG_BUFFER_BYTES: bytes_cfg_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    hin_q      <= hin_d;
    out_data_q <= out_data_d;
  end

  rpb_ram #(.DEPTH(MAX_HANDLES), .WIDTH(HW)) u_handle_fifo (
    .clk_i   (clk_i),
    .we_i    (hf_we),
    .waddr_i (hf_waddr),
    .wdata_i (hf_wdata),
    .re_i    (hf_re),
    .raddr_i (hhead_q),
    .rdata_o (hf_rdata)
  );

  rpb_ram #(.DEPTH(MAX_BUFFERS), .WIDTH(BW)) u_buffer_fifo (
    .clk_i   (clk_i),
    .we_i    (bf_we),
    .waddr_i (bf_waddr),
    .wdata_i (bf_wdata),
    .re_i    (bf_re),
    .raddr_i (bhead_q),
    .rdata_o (bf_rdata)
  );

  rpb_ram #(.DEPTH(MAX_HANDLES), .WIDTH(BW)) u_handle_to_buffer (
    .clk_i   (clk_i),
    .we_i    (hb_we),
    .waddr_i (hb_waddr),
    .wdata_i (hb_wdata),
    .re_i    (hb_re),
    .raddr_i (hb_raddr),
    .rdata_o (hb_rdata)
  );

  rpb_ram #(.DEPTH(MAX_BUFFERS), .WIDTH(RW)) u_buffer_refs (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (rf_re),
    .raddr_i (hb_rdata),
    .rdata_o (rf_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/rpb_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module rpb_ram #(
  parameter int unsigned DEPTH = rpb_pkg::MAX_HANDLES_DEF,
  parameter int unsigned WIDTH = 5
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read strobe
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
